// ===== rtl/core/tickless_systick_timer_macros.svh =====
// -----------------------------------------------------------------------------
// Tickless system tick timer assertion macros
// Shared concurrent assertion forms for the timer checker.
// -----------------------------------------------------------------------------
`ifndef TICKLESS_SYSTICK_TIMER_MACROS_SVH
`define TICKLESS_SYSTICK_TIMER_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define TST_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tickless timer assertion failed");

// Assertion on the block clock and reset.
`define TST_ASSERT(lbl, prop) \
    `TST_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== rtl/core/tst_pkg.sv =====
// -----------------------------------------------------------------------------
// Tickless system tick timer package
// Request and response types, codes and constants shared by the timer files.
// -----------------------------------------------------------------------------
package tst_pkg;

    localparam int REG_W = 16;
    localparam int ACC_W = 32;
    localparam int STEP_W = 6;
    localparam int ADDR_W = 3;

    localparam logic [REG_W-1:0] TICK_PERIOD_RST = 16'd10;
    localparam logic [REG_W-1:0] FEED_PERIOD_RST = 16'd1000;
    localparam logic [STEP_W-1:0] MUL_STEPS = 6'd16;

    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_SLEEP = 2'd1;
    localparam logic [1:0] KIND_WAKE  = 2'd2;

    localparam logic REG_TICK_PERIOD = 1'b0;
    localparam logic REG_FEED_PERIOD = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [REG_W-1:0] sleep_ticks;
    } t_in_req;

    typedef struct packed {
        logic             tick_pulse;
        logic             watchdog_feed;
        logic             woke;
        logic             woke_by_overflow;
        logic [REG_W-1:0] elapsed_ticks;
    } t_out_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic in_stall;
        logic start;
        logic commit;
    } t_ctrl;

endpackage

// ===== rtl/core/tickless_systick_timer.sv =====
// A request commits once the shared unit has finished its multiply work (16 steps)
// or its divide work, and the output is free.
// One request at a time; the next is taken the cycle after commit.
// Reset: synchronous, active low; the timer state and registers return to
// their power-on values.
// -----------------------------------------------------------------------------
// Tickless system tick timer
// Low-power tick counter with tickless sleep, wake reporting and watchdog feed.
// -----------------------------------------------------------------------------
module tickless_systick_timer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tst_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tst_pkg::t_out_rsp               o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tst_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int SUM_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    tst_pkg::t_ctrl                  ctrl;
    logic                            alu_busy;
    logic [tst_pkg::ACC_W-1:0]       product;
    logic [tst_pkg::REG_W-1:0]       quotient;
    tst_pkg::t_op                    alu_op;
    logic [tst_pkg::REG_W-1:0]       mul_a;
    logic [COUNT_WIDTH-1:0]          div_a;
    logic                            out_free;
    logic                            cfg_wr;

    logic [tst_pkg::REG_W-1:0]       r_tick, r_feed_p;
    logic [COUNT_WIDTH-1:0]          r_count, n_count;
    logic [COUNT_WIDTH-1:0]          r_compare, n_compare;
    logic [COUNT_WIDTH-1:0]          r_reload, n_reload;
    logic [COUNT_WIDTH-1:0]          r_spc, n_spc;
    logic                            r_sleeping, n_sleeping;
    logic [COUNT_WIDTH-1:0]          r_feed_last, n_feed_last;
    logic [tst_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic [1:0]                      r_kind;
    tst_pkg::t_out_rsp               r_out, n_out;
    logic                            r_out_valid;

    logic                            ovf;
    logic [COUNT_WIDTH-1:0]          cnt1;
    logic [COUNT_WIDTH-1:0]          cmp_base;
    logic [COUNT_WIDTH-1:0]          cmp_next;
    logic [COUNT_WIDTH-1:0]          delta;
    logic [tst_pkg::ACC_W:0]         acc_sum;
    logic [tst_pkg::ACC_W-1:0]       acc_sat;
    logic                            feed_hit;
    logic [COUNT_WIDTH-1:0]          sleep_len;
    logic [tst_pkg::REG_W-1:0]       elapsed;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = ctrl.in_stall;

    tst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_busy     (alu_busy),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    always_comb begin
        case (i_in_data.kind)
            tst_pkg::KIND_COUNT: alu_op = r_sleeping ? tst_pkg::OP_DIV : tst_pkg::OP_MUL;
            tst_pkg::KIND_SLEEP: alu_op = tst_pkg::OP_MUL;
            tst_pkg::KIND_WAKE:  alu_op = tst_pkg::OP_DIV;
            default:             alu_op = tst_pkg::OP_MUL;
        endcase
        mul_a = (i_in_data.kind == tst_pkg::KIND_SLEEP) ? i_in_data.sleep_ticks : r_feed_p;
        div_a = (i_in_data.kind == tst_pkg::KIND_COUNT) ? r_spc : r_count;
    end

    tst_alu #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.start),
        .i_op       (alu_op),
        .i_mul_a    (mul_a),
        .i_div_a    (div_a),
        .i_b        (r_tick),
        .o_busy     (alu_busy),
        .o_product  (product),
        .o_quotient (quotient)
    );

    always_comb begin
        ovf      = (r_count == r_reload);
        cnt1     = ovf ? '0 : (r_count + COUNT_WIDTH'(1));
        cmp_base = (r_kind == tst_pkg::KIND_COUNT) ? cnt1 : r_count;
        cmp_next = COUNT_WIDTH'(SUM_W'(cmp_base) + SUM_W'(r_tick));
        delta    = cnt1 - r_feed_last;
        acc_sum  = {1'b0, r_acc} + (tst_pkg::ACC_W + 1)'(delta);
        acc_sat  = acc_sum[tst_pkg::ACC_W] ? '1 : acc_sum[tst_pkg::ACC_W-1:0];
        feed_hit = (acc_sat >= product);
        sleep_len = (product > 32'(CNT_MAX)) ? CNT_MAX : product[COUNT_WIDTH-1:0];
        elapsed  = (r_tick == '0) ? '0 : quotient;

        n_count     = r_count;
        n_compare   = r_compare;
        n_reload    = r_reload;
        n_spc       = r_spc;
        n_sleeping  = r_sleeping;
        n_feed_last = r_feed_last;
        n_acc       = r_acc;
        n_out       = '0;

        case (r_kind)
            tst_pkg::KIND_COUNT: begin
                n_count = cnt1;
                if (cnt1 == r_compare) begin
                    n_compare = cmp_next;
                    if (!r_sleeping) begin
                        n_out.tick_pulse = 1'b1;
                        n_feed_last      = cnt1;
                        if (feed_hit) begin
                            n_acc               = '0;
                            n_out.watchdog_feed = 1'b1;
                        end else begin
                            n_acc = acc_sat;
                        end
                    end
                end
                if (ovf && r_sleeping) begin
                    n_out.woke             = 1'b1;
                    n_out.woke_by_overflow = 1'b1;
                    n_out.elapsed_ticks    = elapsed;
                    n_out.watchdog_feed    = 1'b1;
                    n_reload               = CNT_MAX;
                    n_compare              = cmp_next;
                    n_sleeping             = 1'b0;
                    n_acc                  = '0;
                    n_feed_last            = cnt1;
                end
            end
            tst_pkg::KIND_SLEEP: begin
                n_spc      = sleep_len;
                n_reload   = sleep_len;
                n_count    = '0;
                n_sleeping = 1'b1;
            end
            tst_pkg::KIND_WAKE: begin
                if (r_sleeping) begin
                    n_out.woke          = 1'b1;
                    n_out.elapsed_ticks = elapsed;
                    n_reload            = CNT_MAX;
                    n_compare           = cmp_next;
                    n_sleeping          = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_compare   <= COUNT_WIDTH'(tst_pkg::TICK_PERIOD_RST);
            r_reload    <= CNT_MAX;
            r_spc       <= '0;
            r_sleeping  <= 1'b0;
            r_feed_last <= '0;
            r_acc       <= '0;
        end else if (ctrl.commit) begin
            r_count     <= n_count;
            r_compare   <= n_compare;
            r_reload    <= n_reload;
            r_spc       <= n_spc;
            r_sleeping  <= n_sleeping;
            r_feed_last <= n_feed_last;
            r_acc       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.start) begin
            r_kind <= i_in_data.kind;
        end
        if (ctrl.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= tst_pkg::TICK_PERIOD_RST;
            r_feed_p <= tst_pkg::FEED_PERIOD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == tst_pkg::REG_TICK_PERIOD) begin
                r_tick <= pwdata[tst_pkg::REG_W-1:0];
            end else begin
                r_feed_p <= pwdata[tst_pkg::REG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == tst_pkg::REG_FEED_PERIOD) ? {16'd0, r_feed_p}
                                                          : {16'd0, r_tick};

endmodule

// ===== rtl/core/tst_alu.sv =====
// -----------------------------------------------------------------------------
// Tickless timer shared arithmetic unit
// One 18-bit adder stepped one bit per cycle: shift-add multiply or
// restoring divide.
// -----------------------------------------------------------------------------
module tst_alu #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  tst_pkg::t_op                i_op,
    input  logic [tst_pkg::REG_W-1:0]   i_mul_a,
    input  logic [COUNT_WIDTH-1:0]      i_div_a,
    input  logic [tst_pkg::REG_W-1:0]   i_b,
    output logic                        o_busy,
    output logic [tst_pkg::ACC_W-1:0]   o_product,
    output logic [tst_pkg::REG_W-1:0]   o_quotient
);

    logic [16:0]                  r_hi, n_hi;
    logic [31:0]                  r_lo, n_lo;
    logic [tst_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    tst_pkg::t_op                 r_op, n_op;
    logic [tst_pkg::REG_W-1:0]    r_b, n_b;
    logic [16:0]                  trial;
    logic [17:0]                  add_x;
    logic [17:0]                  add_y;
    logic [17:0]                  add_sum;
    logic                         ge;

    always_comb begin
        trial   = {r_hi[15:0], r_lo[31]};
        add_x   = (r_op == tst_pkg::OP_MUL) ? {1'b0, r_hi} : {1'b0, trial};
        add_y   = (r_op == tst_pkg::OP_MUL) ? (r_lo[0] ? {2'b00, r_b} : 18'd0)
                                            : {2'b11, ~r_b};
        add_sum = add_x + add_y + {17'd0, (r_op == tst_pkg::OP_DIV)};
        ge      = ~add_sum[17];
    end

    always_comb begin
        n_hi  = r_hi;
        n_lo  = r_lo;
        n_cnt = r_cnt;
        n_op  = r_op;
        n_b   = r_b;
        if (i_start) begin
            n_op = i_op;
            n_b  = i_b;
            n_hi = '0;
            if (i_op == tst_pkg::OP_MUL) begin
                n_lo  = {16'd0, i_mul_a};
                n_cnt = tst_pkg::MUL_STEPS;
            end else begin
                n_lo  = 32'(i_div_a) << (32 - COUNT_WIDTH);
                n_cnt = tst_pkg::STEP_W'(COUNT_WIDTH);
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (r_op == tst_pkg::OP_MUL) begin
                n_hi = add_sum[17:1];
                n_lo = {add_sum[0], r_lo[31:1]};
            end else begin
                n_hi = ge ? add_sum[16:0] : trial;
                n_lo = {r_lo[30:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_op  <= tst_pkg::OP_MUL;
        end else begin
            r_cnt <= n_cnt;
            r_op  <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_b  <= n_b;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_product  = {r_hi[15:0], r_lo[31:16]};
    assign o_quotient = r_lo[15:0];

endmodule

// ===== rtl/core/tst_ctrl.sv =====
// -----------------------------------------------------------------------------
// Tickless timer sequencer
// Takes one request, runs the shared unit, then commits the result.
// -----------------------------------------------------------------------------
module tst_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_busy,
    input  logic            i_out_free,
    output tst_pkg::t_ctrl  o_ctrl
);

    tst_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tst_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tst_pkg::S_CALC;
                end
            end
            tst_pkg::S_CALC: begin
                if (!i_busy) begin
                    n_state = tst_pkg::S_DONE;
                end
            end
            tst_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = tst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            tst_pkg::S_IDLE: begin
                o_ctrl.start = i_in_valid;
            end
            tst_pkg::S_CALC: begin
                o_ctrl.in_stall = 1'b1;
            end
            tst_pkg::S_DONE: begin
                o_ctrl.in_stall = 1'b1;
                o_ctrl.commit   = i_out_free;
            end
            default: begin
                o_ctrl.in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/tst_checker.sv =====
// -----------------------------------------------------------------------------
// Tickless timer port checker
// Watches the timer ports for request and response consistency.
// -----------------------------------------------------------------------------
`include "tickless_systick_timer_macros.svh"

module tst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input tst_pkg::t_out_rsp o_out_data
);

    logic ovf_wake_ok;

    assign ovf_wake_ok = !o_out_data.woke_by_overflow
                         || (o_out_data.woke && o_out_data.watchdog_feed);

    `TST_ASSERT(a_busy_after_req, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `TST_ASSERT(a_rsp_from_work, $rose(o_out_valid) |-> $past(o_in_stall))
    `TST_ASSERT(a_rsp_held, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
    `TST_ASSERT(a_wake_flags, o_out_valid |-> ovf_wake_ok)
    `TST_ASSERT(a_tick_not_wake, o_out_valid |-> !(o_out_data.tick_pulse && o_out_data.woke))

endmodule

bind tickless_systick_timer tst_checker u_tst_checker (.*);

// ===== tb/tickless_systick_timer_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tickless system tick timer testbench
// Drives count, sleep and wake requests through the request channel. It runs a
// short directed list first and then random sequences under several register
// settings. Each result is checked against a timer model kept in this file or its row's fixed value.
// -----------------------------------------------------------------------------
module tickless_systick_timer_tb;

    localparam int unsigned DIRECTED_ROWS = 25;
    localparam int unsigned PHASES = 9;
    localparam int unsigned PHASE_ITEMS = 205;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    localparam tst_pkg::t_out_rsp RSP_NONE = '0;
    localparam tst_pkg::t_out_rsp RSP_WOKE =
        tst_pkg::t_out_rsp'({1'b0, 1'b0, 1'b1, 1'b0, 16'd0});
    localparam tst_pkg::t_out_rsp RSP_TICK_FEED =
        tst_pkg::t_out_rsp'({1'b1, 1'b1, 1'b0, 1'b0, 16'd0});
    localparam tst_pkg::t_out_rsp RSP_OVF_WAKE =
        tst_pkg::t_out_rsp'({1'b0, 1'b1, 1'b1, 1'b1, 16'd0});

    typedef struct packed {
        tst_pkg::t_in_req  req;
        logic              fixed;
        tst_pkg::t_out_rsp rsp;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    tst_pkg::t_in_req           i_in_data;
    logic                       o_out_valid;
    logic                       i_out_stall;
    tst_pkg::t_out_rsp          o_out_data;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [tst_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    logic [15:0] cfg_tick_period = tst_pkg::TICK_PERIOD_RST;
    logic [15:0] cfg_feed_ticks = tst_pkg::FEED_PERIOD_RST;
    logic [15:0] tmr_count = '0;
    logic [15:0] tmr_compare = tst_pkg::TICK_PERIOD_RST;
    logic [15:0] tmr_reload = 16'hFFFF;
    logic [15:0] tmr_sleep_len = '0;
    logic        tmr_asleep = 1'b0;
    logic [15:0] tmr_fed_at = '0;
    logic [31:0] tmr_accum = '0;

    tst_pkg::t_out_rsp pending_rsp_q[$];
    tst_pkg::t_out_rsp want;
    t_row              plan [DIRECTED_ROWS];

    int errors = 0;
    int unsigned cycles = 0;
    int unsigned n_count = 0, n_sleep = 0, n_wake = 0;
    int unsigned n_tick = 0, n_feed = 0, n_ovf_wake = 0, n_early_wake = 0;

    logic        calm_phase = 1'b0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned run_left = 0;

    tickless_systick_timer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_row row(input logic [1:0] kind, input logic [15:0] ticks,
                                 input logic fixed, input tst_pkg::t_out_rsp rsp);
        row = t_row'({kind, ticks, fixed, rsp});
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Moves the timer model by one request and returns the result it causes.
    function automatic tst_pkg::t_out_rsp advance_timer(input tst_pkg::t_in_req req);
        tst_pkg::t_out_rsp rsp;
        logic              wrapped;
        logic [15:0]       gained;
        logic [32:0]       sum;
        logic [31:0]       limit;
        logic [31:0]       prod;
        rsp = '0;
        case (req.kind)
            tst_pkg::KIND_COUNT: begin
                wrapped = (tmr_count == tmr_reload);
                tmr_count = wrapped ? 16'd0 : tmr_count + 16'd1;
                if (tmr_count == tmr_compare) begin
                    tmr_compare = tmr_count + cfg_tick_period;
                    if (!tmr_asleep) begin
                        gained = tmr_count - tmr_fed_at;
                        sum = {1'b0, tmr_accum} + 33'(gained);
                        limit = 32'(cfg_feed_ticks) * 32'(cfg_tick_period);
                        rsp.tick_pulse = 1'b1;
                        tmr_fed_at = tmr_count;
                        if (sum > 33'h0_FFFF_FFFF) begin
                            sum = 33'h0_FFFF_FFFF;
                        end
                        if (sum >= 33'(limit)) begin
                            sum = '0;
                            rsp.watchdog_feed = 1'b1;
                        end
                        tmr_accum = sum[31:0];
                    end
                end
                if (wrapped && tmr_asleep) begin
                    rsp.woke = 1'b1;
                    rsp.woke_by_overflow = 1'b1;
                    rsp.elapsed_ticks = (cfg_tick_period == 0) ? 16'd0
                                      : tmr_sleep_len / cfg_tick_period;
                    rsp.watchdog_feed = 1'b1;
                    tmr_reload = 16'hFFFF;
                    tmr_compare = tmr_count + cfg_tick_period;
                    tmr_asleep = 1'b0;
                    tmr_accum = '0;
                    tmr_fed_at = tmr_count;
                end
            end
            tst_pkg::KIND_SLEEP: begin
                prod = 32'(req.sleep_ticks) * 32'(cfg_tick_period);
                if (prod > 32'hFFFF) begin
                    prod = 32'hFFFF;
                end
                tmr_sleep_len = prod[15:0];
                tmr_reload = prod[15:0];
                tmr_count = '0;
                tmr_asleep = 1'b1;
            end
            tst_pkg::KIND_WAKE: begin
                if (tmr_asleep) begin
                    rsp.woke = 1'b1;
                    rsp.elapsed_ticks = (cfg_tick_period == 0) ? 16'd0
                                      : tmr_count / cfg_tick_period;
                    tmr_reload = 16'hFFFF;
                    tmr_compare = tmr_count + cfg_tick_period;
                    tmr_asleep = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function void check_field(input string what, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
            errors++;
        end
    endfunction

    task automatic apb_access(input logic wr, input logic [tst_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_register(input logic sel, input logic [15:0] value);
        logic [31:0] rdata;
        apb_access(1'b0, {sel, 2'b00}, '0, rdata);
        if (rdata !== 32'(value)) begin
            $display("%0t ns: register %0d read mismatch, expected %0d, got %0d",
                     $time, sel, value, rdata);
            errors++;
        end
    endtask

    task automatic write_register(input logic sel, input logic [15:0] value);
        logic [31:0] rdata;
        apb_access(1'b1, {sel, 2'b00}, 32'(value), rdata);
        if (sel == tst_pkg::REG_TICK_PERIOD) begin
            cfg_tick_period = value;
        end else begin
            cfg_feed_ticks = value;
        end
        check_register(sel, value);
    endtask

    task automatic offer(input tst_pkg::t_in_req req, input logic fixed,
                         input tst_pkg::t_out_rsp fixed_rsp);
        int unsigned       gap;
        tst_pkg::t_out_rsp pred;
        gap = calm_phase ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pred = advance_timer(req);
        pending_rsp_q.push_back(fixed ? fixed_rsp : pred);
        case (req.kind)
            tst_pkg::KIND_COUNT: n_count++;
            tst_pkg::KIND_SLEEP: n_sleep++;
            default: n_wake++;
        endcase
    endtask

    task automatic offer_item(input logic [1:0] kind, input logic [15:0] ticks);
        offer(tst_pkg::t_in_req'({kind, ticks}), 1'b0, RSP_NONE);
    endtask

    task automatic offer_counts(input int unsigned len);
        repeat (len) offer_item(tst_pkg::KIND_COUNT, 16'($urandom_range(0, 65535)));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_rsp_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, o_out_data);
                errors++;
            end else begin
                want = pending_rsp_q.pop_front();
                check_field("tick_pulse", 16'(want.tick_pulse),
                            16'(o_out_data.tick_pulse));
                check_field("watchdog_feed", 16'(want.watchdog_feed),
                            16'(o_out_data.watchdog_feed));
                check_field("woke", 16'(want.woke), 16'(o_out_data.woke));
                check_field("woke_by_overflow", 16'(want.woke_by_overflow),
                            16'(o_out_data.woke_by_overflow));
                check_field("elapsed_ticks", want.elapsed_ticks, o_out_data.elapsed_ticks);
                n_tick += 32'(want.tick_pulse);
                n_feed += 32'(want.watchdog_feed);
                n_ovf_wake += 32'(want.woke_by_overflow);
                n_early_wake += 32'(want.woke && !want.woke_by_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            i_out_stall <= 1'b1;
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD - 1;
        end else if (calm_phase) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (run_left != 0) begin
            i_out_stall <= 1'b0;
            run_left <= run_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            run_left <= $urandom_range(0, 8);
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycles, pending_rsp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned phase_tp [PHASES];
        int unsigned phase_fp [PHASES];
        int unsigned done, r, len, nap, span;
        logic [15:0] tp, fp;
        logic        held;

        phase_tp = '{10, 1, 65535, 2, 1, 65535, 3, 0, 4};
        phase_fp = '{1000, 1, 65535, 3, 65535, 1, 1, 0, 2};

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_register(tst_pkg::REG_TICK_PERIOD, tst_pkg::TICK_PERIOD_RST);
        check_register(tst_pkg::REG_FEED_PERIOD, tst_pkg::FEED_PERIOD_RST);

        // Two counts per tick and a feed on every tick keep the short list meaningful.
        write_register(tst_pkg::REG_TICK_PERIOD, 16'd2);
        write_register(tst_pkg::REG_FEED_PERIOD, 16'd1);
        plan = '{
            row(tst_pkg::KIND_WAKE,  16'd0,     1'b1, RSP_NONE),
            row(tst_pkg::KIND_SLEEP, 16'hFFFF,  1'b1, RSP_NONE),
            row(tst_pkg::KIND_WAKE,  16'd0,     1'b1, RSP_WOKE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b1, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b1, RSP_TICK_FEED),
            row(tst_pkg::KIND_SLEEP, 16'd0,     1'b1, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b1, RSP_OVF_WAKE),
            row(tst_pkg::KIND_SLEEP, 16'd2,     1'b1, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_SLEEP, 16'd3,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_WAKE,  16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_WAKE,  16'd0,     1'b1, RSP_NONE),
            row(tst_pkg::KIND_SLEEP, 16'd40000, 1'b0, RSP_NONE),
            row(tst_pkg::KIND_SLEEP, 16'd1,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_WAKE,  16'd0,     1'b0, RSP_NONE),
            row(tst_pkg::KIND_COUNT, 16'hFFFF,  1'b0, RSP_NONE)
        };
        foreach (plan[i]) begin
            offer(plan[i].req, plan[i].fixed, plan[i].rsp);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            tp = (phase_tp[p] == 0) ? 16'($urandom_range(1, 8)) : 16'(phase_tp[p]);
            fp = (phase_fp[p] == 0) ? 16'($urandom_range(1, 6)) : 16'(phase_fp[p]);
            write_register(tst_pkg::REG_TICK_PERIOD, tp);
            write_register(tst_pkg::REG_FEED_PERIOD, fp);
            calm_phase <= (p % 3 == 2);
            held = 1'b0;
            done = 0;
            while (done < PHASE_ITEMS) begin
                if ((p == 1 || p == 4) && !held && done >= 60) begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    len = $urandom_range(1, 12);
                    offer_counts(len);
                    done += len;
                end else if (r < 65) begin
                    // Short sleep; unless it spans more than 36 counts, the counts run into the overflow wake.
                    nap = $urandom_range(0, 3);
                    span = nap * cfg_tick_period;
                    len = (span > 36) ? $urandom_range(1, 40) : span + $urandom_range(1, 3);
                    offer_item(tst_pkg::KIND_SLEEP, 16'(nap));
                    offer_counts(len);
                    done += len + 1;
                end else if (r < 82) begin
                    len = $urandom_range(0, 8);
                    offer_item(tst_pkg::KIND_SLEEP, 16'($urandom_range(0, 6)));
                    offer_counts(len);
                    offer_item(tst_pkg::KIND_WAKE, 16'($urandom_range(0, 65535)));
                    done += len + 2;
                end else if (r < 90) begin
                    len = $urandom_range(0, 6);
                    offer_item(tst_pkg::KIND_SLEEP, 16'($urandom_range(0, 65535)));
                    offer_counts(len);
                    offer_item(tst_pkg::KIND_WAKE, 16'($urandom_range(0, 65535)));
                    done += len + 2;
                end else begin
                    offer_item(2'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
                    done += 1;
                end
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests (%0d counts, %0d sleeps, %0d wakes) over %0d settings.",
                 n_count + n_sleep + n_wake, n_count, n_sleep, n_wake, PHASES + 1);
        $display("Saw %0d ticks, %0d watchdog feeds, %0d overflow wakes, %0d early wakes.",
                 n_tick, n_feed, n_ovf_wake, n_early_wake);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== tickless_systick_timer.f =====
+incdir+rtl/core
rtl/core/tst_pkg.sv
rtl/core/tst_alu.sv
rtl/core/tst_ctrl.sv
rtl/core/tickless_systick_timer.sv
rtl/core/tst_checker.sv
tb/tickless_systick_timer_tb.sv
